// File: design/ipal_pkg.sv
package ipal_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned AddrWidth       = 32;
  localparam int unsigned PrefixWidth     = 6;
  localparam int unsigned BootEntries     = 8;
  localparam logic [PrefixWidth-1:0] MaxPrefix = 6'd32;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  // sequencer to datapath
  typedef struct packed {
    logic busy;
    logic rd_en;
    logic chk_vld;
    logic commit;
  } ctrl_t;

  function automatic logic [AddrWidth-1:0] prefix_mask(input logic [PrefixWidth-1:0] len);
    logic [AddrWidth-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= MaxPrefix) begin
      m = '1;
    end else begin
      m = {AddrWidth{1'b1}} << (MaxPrefix - len);
    end
    return m;
  endfunction

  function automatic logic [AddrWidth-1:0] boot_net(input logic [2:0] idx);
    logic [AddrWidth-1:0] n;
    unique case (idx)
      3'd0: n = 32'h7F00_0000;
      3'd1: n = 32'hA9FE_0000;
      3'd2: n = 32'h0808_0808;
      3'd3: n = 32'h0808_0404;
      3'd4: n = 32'h0101_0101;
      3'd5: n = 32'h0100_0001;
      3'd6: n = 32'hD043_DEDE;
      3'd7: n = 32'hD043_DCDC;
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [PrefixWidth-1:0] boot_len(input logic [2:0] idx);
    logic [PrefixWidth-1:0] l;
    unique case (idx)
      3'd0:    l = 6'd8;
      3'd1:    l = 6'd16;
      default: l = MaxPrefix;
    endcase
    return l;
  endfunction

endpackage

// File: design/ipv4_prefix_allowlist_table_top.sv
// Channel   Ports                                  Direction  Transaction when
// request   start_i, func_i, addr_i, prefix_len_i  in         start_i && !busy_o at clk_i
// result    done_o, allowed_o, status_o            out        done_o high (one cycle)
//
// After acceptance the sequencer walks the table one slot a cycle through
// the registered RAM read port, then drains the last read and commits.
// The result strobe rises in the cycle after commit, when a new request may
// already be accepted. rst_ni restores the valid bits to the eight defaults,
// which read from constants until overwritten. The receiver cannot stall.
module ipv4_prefix_allowlist_table_top #(
  parameter int unsigned TableEntries = ipal_pkg::TableEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      func_i,
  input  logic [ipal_pkg::AddrWidth-1:0]   addr_i,
  input  logic [ipal_pkg::PrefixWidth-1:0] prefix_len_i,
  output logic                            done_o,
  output logic                            allowed_o,
  output logic [1:0]                      status_o
);
  import ipal_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned EntW = AddrWidth + PrefixWidth;

  ctrl_t ctl;
  logic [IdxW-1:0] rd_idx, chk_idx;

  // latched request
  logic [1:0]             func_q;
  logic [AddrWidth-1:0]   addr_q;
  logic [PrefixWidth-1:0] len_q;

  // scan results
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  // per-slot state
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [TableEntries-1:0] written_q, written_d;

  // result registers
  logic    done_q, done_d;
  logic    allowed_q, allowed_d;
  status_e status_q, status_d;

  logic                   accept;
  logic                   ram_we;
  logic [EntW-1:0]        ram_rdata;
  logic [AddrWidth-1:0]   ent_net;
  logic [PrefixWidth-1:0] ent_len;
  logic                   ent_vld;
  logic                   match;

  assign accept = start_i && !ctl.busy;
  assign busy_o = ctl.busy;

  ipal_ctrl #(
    .TableEntries(TableEntries)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i  (accept),
    .ctl_o    (ctl),
    .rd_idx_o (rd_idx),
    .chk_idx_o(chk_idx)
  );

  ipal_ram #(
    .Width(EntW),
    .Depth(TableEntries)
  ) u_ram (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i({addr_q, len_q}),
    .re_i   (ctl.rd_en),
    .raddr_i(rd_idx),
    .rdata_o(ram_rdata)
  );

  // Slots never written hold the boot defaults; only the first eight can be valid then.
  always_comb begin
    if (written_q[chk_idx]) begin
      ent_net = ram_rdata[EntW-1:PrefixWidth];
      ent_len = ram_rdata[PrefixWidth-1:0];
    end else begin
      ent_net = boot_net(chk_idx[2:0]);
      ent_len = boot_len(chk_idx[2:0]);
    end
    ent_vld = valid_q[chk_idx];
  end

  ipal_match u_match (
    .exact_i   (func_q != FUNC_LOOKUP),
    .key_addr_i(addr_q),
    .key_len_i (len_q),
    .ent_vld_i (ent_vld),
    .ent_net_i (ent_net),
    .ent_len_i (ent_len),
    .hit_o     (match)
  );

  // Accumulate the first hit and the lowest free slot as the scan advances.
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (accept) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (ctl.chk_vld) begin
      if (!hit_q && match) begin
        hit_d     = 1'b1;
        hit_idx_d = chk_idx;
      end
      if (!free_q && !ent_vld) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx;
      end
    end
  end

  // Commit: update the table and form the result.
  always_comb begin
    valid_d   = valid_q;
    written_d = written_q;
    ram_we    = 1'b0;
    done_d    = 1'b0;
    allowed_d = allowed_q;
    status_d  = status_q;
    if (ctl.commit) begin
      done_d    = 1'b1;
      allowed_d = 1'b0;
      status_d  = STAT_DONE;
      unique case (func_q)
        FUNC_LOOKUP: allowed_d = hit_q;
        FUNC_ADD: begin
          priority if (hit_q) begin
            status_d = STAT_MISS;
          end else if (free_q) begin
            ram_we                = 1'b1;
            valid_d[free_idx_q]   = 1'b1;
            written_d[free_idx_q] = 1'b1;
          end else begin
            status_d = STAT_FULL;
          end
        end
        FUNC_REMOVE: begin
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
          end else begin
            status_d = STAT_MISS;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      done_q    <= 1'b0;
      valid_q   <= TableEntries'({BootEntries{1'b1}});
      written_q <= '0;
    end else begin
      hit_q     <= hit_d;
      free_q    <= free_d;
      done_q    <= done_d;
      valid_q   <= valid_d;
      written_q <= written_d;
    end
  end

  // Payload: hold the request and result, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      addr_q <= addr_i;
      len_q  <= (prefix_len_i > MaxPrefix) ? MaxPrefix : prefix_len_i;
    end
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    allowed_q  <= allowed_d;
    status_q   <= status_d;
  end

  assign done_o    = done_q;
  assign allowed_o = allowed_q;
  assign status_o  = status_q;

  // A result follows a commit cycle and nothing else.
  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(ctl.commit))
    else $error("result strobe without a commit");

  // An accepted request makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepting a request");

  // Only an add can report a full table.
  a_full_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (func_q == FUNC_ADD) || (status_o != STAT_FULL))
    else $error("table full reported for a non-add request");

  // Only a lookup can report an allowed address.
  a_allowed_only_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && allowed_o) |-> (func_q == FUNC_LOOKUP))
    else $error("allowed set for a non-lookup request");

endmodule

// File: design/ipal_ram.sv
module ipal_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ipal_match.sv
module ipal_match (
  input  logic                            exact_i,
  input  logic [ipal_pkg::AddrWidth-1:0]   key_addr_i,
  input  logic [ipal_pkg::PrefixWidth-1:0] key_len_i,
  input  logic                            ent_vld_i,
  input  logic [ipal_pkg::AddrWidth-1:0]   ent_net_i,
  input  logic [ipal_pkg::PrefixWidth-1:0] ent_len_i,
  output logic                            hit_o
);
  import ipal_pkg::*;

  logic [AddrWidth-1:0] mask;

  always_comb begin
    mask = prefix_mask(ent_len_i);
    if (exact_i) begin
      hit_o = ent_vld_i && (ent_net_i == key_addr_i) && (ent_len_i == key_len_i);
    end else begin
      hit_o = ent_vld_i && ((key_addr_i & mask) == (ent_net_i & mask));
    end
  end

endmodule

// File: design/ipal_ctrl.sv
module ipal_ctrl #(
  parameter int unsigned TableEntries = ipal_pkg::TableEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output ipal_pkg::ctrl_t                 ctl_o,
  output logic [$clog2(TableEntries)-1:0] rd_idx_o,
  output logic [$clog2(TableEntries)-1:0] chk_idx_o
);
  import ipal_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            chk_vld_q;
  logic [IdxW-1:0] chk_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= ctl_o.rd_en;
      chk_idx_q <= cnt_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    ctl_o.busy    = 1'b1;
    ctl_o.rd_en   = 1'b0;
    ctl_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.busy = 1'b0;
        cnt_d      = '0;
        if (start_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.rd_en = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    ctl_o.chk_vld = chk_vld_q;
  end

  assign rd_idx_o  = cnt_q;
  assign chk_idx_o = chk_idx_q;

endmodule

// File: verif/ipv4_prefix_allowlist_table_top_tb.sv
`timescale 1ns / 1ps

module ipv4_prefix_allowlist_table_top_tb;
  import ipal_pkg::*;

  localparam int Slots          = TableEntriesDef;
  localparam int RandomRequests = 1600;
  // Slowest request: the longest random gap plus a full table scan. Allow
  // roughly eight times that over every request.
  localparam int CycleLimit     = 400000;
  // func value that the block must treat as a no-op
  localparam logic [1:0] FuncReserved = 2'd3;

  typedef struct packed {
    logic    allowed;
    status_e status;
  } outcome_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [1:0]             func_i;
  logic [AddrWidth-1:0]   addr_i;
  logic [PrefixWidth-1:0] prefix_len_i;
  logic                   done_o;
  logic                   allowed_o;
  logic [1:0]             status_o;

  // Shadow copy of the entry table, updated at the acceptance of each request.
  logic                   slot_used [Slots];
  logic [AddrWidth-1:0]   slot_net  [Slots];
  logic [PrefixWidth-1:0] slot_len  [Slots];

  outcome_t pending_outcomes[$];
  int       mismatches    = 0;
  int       cycle_count   = 0;
  bit       steady_stream = 1'b0;

  ipv4_prefix_allowlist_table_top #(
    .TableEntries(Slots)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .prefix_len_i(prefix_len_i),
    .done_o      (done_o),
    .allowed_o   (allowed_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Network mask for a stored prefix length: zero length matches everything,
  // anything from 32 up keeps the whole address.
  function automatic logic [AddrWidth-1:0] net_mask(input logic [PrefixWidth-1:0] len);
    if (len == 0) return '0;
    if (len >= 32) return '1;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // Load the eight boot-time entries: loopback /8, link-local /16 and six
  // public resolver hosts.
  function automatic void load_boot_entries();
    logic [AddrWidth-1:0] nets [8];
    nets = '{32'h7F00_0000, 32'hA9FE_0000, 32'h0808_0808, 32'h0808_0404,
             32'h0101_0101, 32'h0100_0001, 32'hD043_DEDE, 32'hD043_DCDC};
    for (int i = 0; i < Slots; i++) begin
      slot_used[i] = (i < 8);
      slot_net[i]  = (i < 8) ? nets[i] : '0;
      slot_len[i]  = (i == 0) ? 6'd8 : (i == 1) ? 6'd16 : (i < 8) ? 6'd32 : 6'd0;
    end
  endfunction

  // Slot holding exactly this (network, length) pair, or -1.
  function automatic int find_pair(input logic [AddrWidth-1:0] net,
                                   input logic [PrefixWidth-1:0] len);
    for (int i = 0; i < Slots; i++) begin
      if (slot_used[i] && slot_net[i] == net && slot_len[i] == len) return i;
    end
    return -1;
  endfunction

  // Work out what one request returns and apply its effect to the shadow table.
  function automatic outcome_t table_outcome(input logic [1:0] op,
                                             input logic [AddrWidth-1:0] addr,
                                             input logic [PrefixWidth-1:0] len_in);
    outcome_t             res;
    logic [PrefixWidth-1:0] len;
    int                   slot;
    res.allowed = 1'b0;
    res.status  = STAT_DONE;
    len = (len_in > MaxPrefix) ? MaxPrefix : len_in;
    case (op)
      FUNC_LOOKUP: begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_used[i] &&
              (addr & net_mask(slot_len[i])) == (slot_net[i] & net_mask(slot_len[i])))
            res.allowed = 1'b1;
        end
      end
      FUNC_ADD: begin
        if (find_pair(addr, len) >= 0) begin
          res.status = STAT_MISS;
        end else begin
          slot = -1;
          for (int i = Slots - 1; i >= 0; i--) begin
            if (!slot_used[i]) slot = i;
          end
          if (slot < 0) begin
            res.status = STAT_FULL;
          end else begin
            slot_used[slot] = 1'b1;
            slot_net[slot]  = addr;
            slot_len[slot]  = len;
          end
        end
      end
      FUNC_REMOVE: begin
        slot = find_pair(addr, len);
        if (slot < 0) begin
          res.status = STAT_MISS;
        end else begin
          slot_used[slot] = 1'b0;
          slot_net[slot]  = '0;
          slot_len[slot]  = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly ordinary lengths, now and then an oversized one that must saturate,
  // and rarely a zero length, which would otherwise swamp every lookup.
  function automatic logic [PrefixWidth-1:0] draw_prefix();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return 6'd0;
    if (r < 4) return 6'($urandom_range(33, 63));
    return 6'($urandom_range(1, 32));
  endfunction

  // Issue one request: once the block is free, hold off for a random gap (or
  // none while streaming), present the fields at the falling edge and keep
  // them until the transaction is taken. Predict at the accepting edge.
  task automatic send_request(input logic [1:0] op,
                              input logic [AddrWidth-1:0] addr,
                              input logic [PrefixWidth-1:0] len);
    int gap;
    gap = steady_stream ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      while (busy_o) @(negedge clk_i);
      repeat (gap) @(negedge clk_i);
    end
    func_i       <= op;
    addr_i       <= addr;
    prefix_len_i <= len;
    start_i      <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_outcomes = {pending_outcomes, table_outcome(op, addr, len)};
    // Flip between gapped traffic and back-to-back streams now and then.
    if ($urandom_range(0, 39) == 0) steady_stream = !steady_stream;
  endtask

  // Lookups against the boot entries, on and just off their boundaries.
  task automatic test_boot_entries();
    send_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 6'h3F);  // top of loopback /8
    send_request(FUNC_LOOKUP, 32'h7EFF_FFFF, 6'd0);   // just below it
    send_request(FUNC_LOOKUP, 32'hA9FE_FFFF, 6'd0);   // inside link-local /16
    send_request(FUNC_LOOKUP, 32'hA9FF_0000, 6'd0);   // just above it
    send_request(FUNC_LOOKUP, 32'h0100_0001, 6'd32);  // exact host entry
    send_request(FUNC_LOOKUP, 32'h0808_0809, 6'd32);  // neighbour of a host entry
    send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    send_request(FUNC_LOOKUP, 32'h0000_0000, 6'd0);
  endtask

  task automatic test_special_cases();
    // Duplicates of boot hosts, once plainly and once with an oversized length.
    send_request(FUNC_ADD, 32'h0808_0808, 6'd32);
    send_request(FUNC_ADD, 32'h0101_0101, 6'd63);
    send_request(FUNC_REMOVE, 32'h0A00_0000, 6'd8);   // absent pair
    // Host bits set: stored as given, matched under the mask, removed exactly.
    send_request(FUNC_ADD, 32'h0A00_0005, 6'd8);
    send_request(FUNC_LOOKUP, 32'h0AC8_0000, 6'd0);
    send_request(FUNC_REMOVE, 32'h0A00_0000, 6'd8);
    send_request(FUNC_REMOVE, 32'h0A00_0005, 6'd8);
    send_request(FuncReserved, 32'hFFFF_FFFF, 6'h3F);
    // Zero-length entry matches any address.
    send_request(FUNC_ADD, 32'h0000_0000, 6'd0);
    send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    send_request(FUNC_REMOVE, 32'h0000_0000, 6'd0);
  endtask

  task automatic test_full_table();
    for (int i = 8; i < Slots; i++)
      send_request(FUNC_ADD, 32'hC0A8_0000 | (i << 8), 6'd24);
    send_request(FUNC_ADD, 32'hC633_6400, 6'd24);     // no free slot
    send_request(FUNC_ADD, 32'hC0A8_0800, 6'd24);     // duplicate wins over full
    // Free a middle slot; the next add must land there.
    send_request(FUNC_REMOVE, 32'h0808_0808, 6'd32);
    send_request(FUNC_ADD, 32'h0808_0808, 6'd40);
    send_request(FUNC_LOOKUP, 32'h0808_0808, 6'd0);
  endtask

  // Mostly well-formed traffic built from the live table: lookups near stored
  // networks, exact removes and duplicates, with random noise mixed in. The
  // add/remove balance swaps every hundred requests so the table fills and
  // drains repeatedly.
  task automatic test_random_traffic();
    int                     r;
    int                     pick;
    int                     live [$];
    bit                     add_heavy;
    logic [AddrWidth-1:0]   a;
    logic [AddrWidth-1:0]   m;
    logic [PrefixWidth-1:0] l;
    for (int n = 0; n < RandomRequests; n++) begin
      live = {};
      for (int i = 0; i < Slots; i++) begin
        if (slot_used[i]) live = {live, i};
      end
      pick = (live.size() > 0) ? live[$urandom_range(0, live.size() - 1)] : -1;
      add_heavy = ((n / 100) % 2) == 0;
      r = $urandom_range(0, 99);
      a = $urandom;
      l = draw_prefix();
      if (r < 40) begin
        if (pick >= 0 && $urandom_range(0, 1) == 0) begin
          // Keep the masked part, randomise the host part; sometimes knock
          // one network bit to miss narrowly.
          m = net_mask(slot_len[pick]);
          a = (slot_net[pick] & m) | (a & ~m);
          if (slot_len[pick] > 0 && $urandom_range(0, 2) == 0)
            a = a ^ (32'h1 << (32 - $urandom_range(1, slot_len[pick])));
        end
        send_request(FUNC_LOOKUP, a, 6'($urandom));
      end else if (r < (add_heavy ? 75 : 55)) begin
        if (pick >= 0 && $urandom_range(0, 3) == 0) begin
          a = slot_net[pick];
          l = (slot_len[pick] == 32 && $urandom_range(0, 1) == 1) ?
              6'($urandom_range(33, 63)) : slot_len[pick];
        end
        send_request(FUNC_ADD, a, l);
      end else if (r < 94) begin
        if (pick >= 0 && $urandom_range(0, 3) != 0) begin
          a = slot_net[pick];
          l = (slot_len[pick] == 32 && $urandom_range(0, 1) == 1) ?
              6'($urandom_range(33, 63)) : slot_len[pick];
        end else if (pick >= 0 && $urandom_range(0, 1) == 0) begin
          // Right network, wrong length.
          a = slot_net[pick];
          l = (slot_len[pick] == 0) ? 6'd1 : slot_len[pick] - 6'd1;
        end
        send_request(FUNC_REMOVE, a, l);
      end else begin
        send_request(FuncReserved, a, 6'($urandom));
      end
    end
  endtask

  // Compare each result strobe with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no outstanding request: allowed %0d status %0d",
               allowed_o, status_o);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (allowed_o !== want.allowed) begin
          $error("allowed: expected %0d, actual %0d", want.allowed, allowed_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    func_i       = FUNC_LOOKUP;
    addr_i       = '0;
    prefix_len_i = '0;
    load_boot_entries();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_boot_entries();
    test_special_cases();
    test_full_table();
    test_random_traffic();

    // Drop the request line, let every outstanding result arrive, then
    // advance past one more full request time to catch stray strobes.
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (Slots + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
